// ----- rtl/rwnh_pkg.sv -----
// shared constants and types for the ray/wall nearest hit core
package rwnh_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 8;
   localparam int MAX_WALLS  = 32;
   localparam int DIST_BITS  = 12;
   localparam int DIST_MAX   = 4095;
   localparam int COUNT_BITS = 6;

   // command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_CAST = 1'b1;

   // register indexes
   localparam logic REG_WALL_COUNT = 1'b0;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
      logic signed [COORD_BITS-1:0] bx;
      logic signed [COORD_BITS-1:0] by;
   } wall_type;

endpackage

// ----- rtl/ray_wall_nearest_hit_core.sv -----
// top level of the ray/wall nearest hit core
//
// channel   direction  handshake                 payload
// req_*     in         start && !busy            command, wall slot, two points
// rsp_*     out        rsp_valid, one cycle      hit, end point (q.8), distance
// apb       in/out     psel && penable && pwrite wall_count at byte address 0
//
// a load transaction writes the wall ram from the request ports and busy stays low
// a cast transaction first takes the square root of the ray length, then reads and
// tests the walls in turn; every wall that is actually hit costs two 20-step divisions
// and one 13-step square root on the shared units
// reset is synchronous; the wall ram is not cleared and needs no clearing pass
// the receiver cannot stall: rsp_valid is high for exactly one cycle per cast
module ray_wall_nearest_hit_core #(
   parameter int MAX_WALLS = rwnh_pkg::MAX_WALLS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request side
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_command,
   input  logic [4:0]                             req_wall_slot,
   input  logic signed [rwnh_pkg::COORD_BITS-1:0] req_point_a_x,
   input  logic signed [rwnh_pkg::COORD_BITS-1:0] req_point_a_y,
   input  logic signed [rwnh_pkg::COORD_BITS-1:0] req_point_b_x,
   input  logic signed [rwnh_pkg::COORD_BITS-1:0] req_point_b_y,
   // response side
   output logic                                   rsp_valid,
   output logic                                   rsp_hit,
   output logic signed [rwnh_pkg::COORD_BITS+rwnh_pkg::FRAC_BITS-1:0] rsp_end_x,
   output logic signed [rwnh_pkg::COORD_BITS+rwnh_pkg::FRAC_BITS-1:0] rsp_end_y,
   output logic [rwnh_pkg::DIST_BITS-1:0]         rsp_distance,
   // register port
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [2:0]                             paddr,
   input  logic [31:0]                            pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);

   localparam int CB   = rwnh_pkg::COORD_BITS;
   localparam int FB   = rwnh_pkg::FRAC_BITS;
   localparam int EB   = CB + FB;          // q.8 point coordinate
   localparam int DW   = EB + 1;           // q.8 ray delta
   localparam int MW   = DW - 1;           // magnitude of a ray delta
   localparam int QW   = CB + 1;           // integer wall delta
   localparam int PW   = DW + QW + 1;      // den, tn, un
   localparam int LO   = (PW + 1) / 2;     // split of tn for the hit point product
   localparam int HI   = PW - LO;
   localparam int NW   = PW + MW;          // tn * |delta|
   localparam int SQW  = 2 * MW + 1;       // sum of squares
   localparam int SVW  = SQW - 2 * FB;     // integer part of it
   localparam int SRW  = SVW + (SVW % 2);
   localparam int IT   = SRW / 2;          // root bits
   localparam int SCW  = $clog2(IT + 1);
   localparam int AW   = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
   localparam int NBW  = rwnh_pkg::COUNT_BITS;
   localparam int WW   = $bits(rwnh_pkg::wall_type);

   typedef enum logic [4:0] {
      ST_IDLE, ST_SQX, ST_SQY, ST_SQ_LD, ST_SQ_RUN, ST_SQ_END,
      ST_WALL_RD, ST_WALL_LD, ST_MUL_DEN, ST_MUL_TN, ST_MUL_UN,
      ST_NORM, ST_TEST, ST_MUL_LO, ST_MUL_HI, ST_DIV_GO, ST_DIV_WAIT
   } state_type;

   state_type state_ff;

   // configuration
   logic [NBW-1:0] wall_count_ff;
   logic           cfg_wr;

   // ray state
   logic signed [CB-1:0] ax_ff, ay_ff;
   logic signed [EB-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic signed [DW-1:0] dpx_ff, dpy_ff;
   logic signed [DW-1:0] hqx_ff, hqy_ff;
   logic [NBW-1:0]       idx_ff, n_ff;
   logic                 hit_ff;
   logic                 init_ff;
   logic                 axis_ff;
   logic [IT-1:0]        cur_dist_ff;

   // current wall
   logic signed [QW-1:0] qdx_ff, qdy_ff, rx_ff, ry_ff;
   logic signed [PW-1:0] den_ff, tn_ff, un_ff;

   // hit point product and root
   logic [LO+MW-1:0]  plo_ff;
   logic [HI+MW-1:0]  phi_ff;
   logic [2*MW-1:0]   sqa_ff, sqb_ff;
   logic [SRW-1:0]    sv_ff, sres_ff, sbit_ff;
   logic [SCW-1:0]    scnt_ff;

   // outputs
   logic                 rsp_valid_ff, rsp_hit_ff;
   logic signed [EB-1:0] rsp_end_x_ff, rsp_end_y_ff;
   logic [rwnh_pkg::DIST_BITS-1:0] rsp_distance_ff;

   // ram
   logic                 ram_wr, ram_rd;
   logic [AW-1:0]        ram_wr_addr, ram_rd_addr;
   logic [31:0]          slot_ext, idx_ext;
   rwnh_pkg::wall_type   wall_in, wall_rd;
   logic [WW-1:0]        ram_rd_data;

   // shared multiplier pair
   logic signed [DW-1:0] ma1, ma2;
   logic signed [QW-1:0] mb1, mb2;
   logic signed [PW-1:0] p1, p2, prod;

   // misc combinational
   logic                 accept;
   logic signed [DW-1:0] dpx_in, dpy_in;
   logic signed [DW-1:0] absx, absy, sq_src_x, sq_src_y, sq_abs_x, sq_abs_y;
   logic [MW-1:0]        mag;
   logic [SQW-1:0]       sq_sum;
   logic [SRW-1:0]       sq_try;
   logic                 div_start, div_done, div_rem_nz;
   logic [MW-1:0]        div_quot;
   logic [NW-1:0]        div_numer;
   logic signed [DW-1:0] q_signed, q_plus;
   logic                 q_neg;
   logic [IT-1:0]        new_dist;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // register port
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && (paddr[2] == rwnh_pkg::REG_WALL_COUNT);
   assign prdata = (paddr[2] == rwnh_pkg::REG_WALL_COUNT) ? 32'(wall_count_ff) : 32'd0;

   // wall table: loads write straight from the request ports
   assign slot_ext    = 32'(req_wall_slot);
   assign ram_wr      = accept && (req_command == rwnh_pkg::CMD_LOAD) && (slot_ext < MAX_WALLS);
   assign ram_wr_addr = slot_ext[AW-1:0];
   assign wall_in     = '{ax: req_point_a_x, ay: req_point_a_y,
                          bx: req_point_b_x, by: req_point_b_y};
   assign idx_ext     = 32'(idx_ff);
   assign ram_rd_addr = idx_ext[AW-1:0];
   assign ram_rd      = (state_ff == ST_WALL_RD) && (idx_ff != n_ff);
   assign wall_rd     = ram_rd_data;

   rwnh_ram #(
      .WIDTH (WW),
      .DEPTH (MAX_WALLS)
   ) u_wall_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (ram_wr_addr),
      .wr_data (wall_in),
      .rd_en   (ram_rd),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // initial ray delta in q.8
   assign dpx_in = (DW'(req_point_b_x) - DW'(req_point_a_x)) <<< FB;
   assign dpy_in = (DW'(req_point_b_y) - DW'(req_point_a_y)) <<< FB;

   // cross products: one pair of multipliers, operands picked by state
   always_comb begin
      ma1 = '0;
      mb1 = '0;
      ma2 = '0;
      mb2 = '0;
      case (state_ff)
         ST_MUL_DEN: begin
            ma1 = dpx_ff;      mb1 = qdy_ff;
            ma2 = dpy_ff;      mb2 = qdx_ff;
         end
         ST_MUL_TN: begin
            ma1 = DW'(rx_ff);  mb1 = qdy_ff;
            ma2 = DW'(ry_ff);  mb2 = qdx_ff;
         end
         ST_MUL_UN: begin
            ma1 = dpy_ff;      mb1 = rx_ff;
            ma2 = dpx_ff;      mb2 = ry_ff;
         end
         default: begin
            ma1 = '0;
         end
      endcase
   end

   assign p1   = ma1 * mb1;
   assign p2   = ma2 * mb2;
   assign prod = p1 - p2;

   // magnitudes for the hit point product
   assign absx = dpx_ff[DW-1] ? -dpx_ff : dpx_ff;
   assign absy = dpy_ff[DW-1] ? -dpy_ff : dpy_ff;
   assign mag  = axis_ff ? absy[MW-1:0] : absx[MW-1:0];

   // squares for the floor distance
   assign sq_src_x = init_ff ? dpx_ff : hqx_ff;
   assign sq_src_y = init_ff ? dpy_ff : hqy_ff;
   assign sq_abs_x = sq_src_x[DW-1] ? -sq_src_x : sq_src_x;
   assign sq_abs_y = sq_src_y[DW-1] ? -sq_src_y : sq_src_y;
   assign sq_sum   = SQW'(sqa_ff) + SQW'(sqb_ff);
   assign sq_try   = sres_ff + sbit_ff;
   assign new_dist = sres_ff[IT-1:0];

   // divider: floor(tn * |delta| / den), sign fixed up afterwards
   assign div_start = (state_ff == ST_DIV_GO);
   assign div_numer = NW'(plo_ff) + (NW'(phi_ff) << LO);

   rwnh_div #(
      .NUM_W  (NW),
      .DEN_W  (PW),
      .QUOT_W (MW)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .numer  (div_numer),
      .denom  (den_ff),
      .done   (div_done),
      .quot   (div_quot),
      .rem_nz (div_rem_nz)
   );

   // negative delta rounds toward minus infinity: -(q + (rem != 0))
   assign q_neg    = axis_ff ? dpy_ff[DW-1] : dpx_ff[DW-1];
   assign q_plus   = DW'(div_quot) + DW'(div_rem_nz);
   assign q_signed = q_neg ? -q_plus : DW'(div_quot);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wall_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         hit_ff        <= 1'b0;
         init_ff       <= 1'b0;
         axis_ff       <= 1'b0;
         idx_ff        <= '0;
         n_ff          <= '0;
         scnt_ff       <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (cfg_wr) begin
            wall_count_ff <= pwdata[NBW-1:0];
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_command == rwnh_pkg::CMD_CAST)) begin
                  ax_ff   <= req_point_a_x;
                  ay_ff   <= req_point_a_y;
                  sx_ff   <= EB'(req_point_a_x) <<< FB;
                  sy_ff   <= EB'(req_point_a_y) <<< FB;
                  ex_ff   <= EB'(req_point_b_x) <<< FB;
                  ey_ff   <= EB'(req_point_b_y) <<< FB;
                  dpx_ff  <= dpx_in;
                  dpy_ff  <= dpy_in;
                  hit_ff  <= 1'b0;
                  init_ff <= 1'b1;
                  idx_ff  <= '0;
                  if (32'(wall_count_ff) > MAX_WALLS) begin
                     n_ff <= NBW'(MAX_WALLS);
                  end else begin
                     n_ff <= wall_count_ff;
                  end
                  state_ff <= ST_SQX;
               end
            end
            ST_SQX: begin
               sqa_ff   <= sq_abs_x[MW-1:0] * sq_abs_x[MW-1:0];
               state_ff <= ST_SQY;
            end
            ST_SQY: begin
               sqb_ff   <= sq_abs_y[MW-1:0] * sq_abs_y[MW-1:0];
               state_ff <= ST_SQ_LD;
            end
            ST_SQ_LD: begin
               sv_ff    <= SRW'(sq_sum >> (2 * FB));
               sres_ff  <= '0;
               sbit_ff  <= SRW'(1) << (SRW - 2);
               scnt_ff  <= SCW'(IT);
               state_ff <= ST_SQ_RUN;
            end
            ST_SQ_RUN: begin
               if (sv_ff >= sq_try) begin
                  sv_ff   <= sv_ff - sq_try;
                  sres_ff <= (sres_ff >> 1) + sbit_ff;
               end else begin
                  sres_ff <= sres_ff >> 1;
               end
               sbit_ff <= sbit_ff >> 2;
               scnt_ff <= scnt_ff - 1'b1;
               if (scnt_ff == SCW'(1)) begin
                  state_ff <= ST_SQ_END;
               end
            end
            ST_SQ_END: begin
               if (init_ff) begin
                  cur_dist_ff <= new_dist;
                  init_ff     <= 1'b0;
               end else begin
                  // equal floor distance still moves the end
                  if (cur_dist_ff >= new_dist) begin
                     ex_ff       <= sx_ff + EB'(hqx_ff);
                     ey_ff       <= sy_ff + EB'(hqy_ff);
                     dpx_ff      <= hqx_ff;
                     dpy_ff      <= hqy_ff;
                     cur_dist_ff <= new_dist;
                     hit_ff      <= 1'b1;
                  end
                  idx_ff <= idx_ff + 1'b1;
               end
               state_ff <= ST_WALL_RD;
            end
            ST_WALL_RD: begin
               if (idx_ff == n_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_hit_ff   <= hit_ff;
                  rsp_end_x_ff <= ex_ff;
                  rsp_end_y_ff <= ey_ff;
                  if (cur_dist_ff > IT'(rwnh_pkg::DIST_MAX)) begin
                     rsp_distance_ff <= rwnh_pkg::DIST_BITS'(rwnh_pkg::DIST_MAX);
                  end else begin
                     rsp_distance_ff <= rwnh_pkg::DIST_BITS'(cur_dist_ff);
                  end
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_WALL_LD;
               end
            end
            ST_WALL_LD: begin
               qdx_ff   <= QW'(wall_rd.bx) - QW'(wall_rd.ax);
               qdy_ff   <= QW'(wall_rd.by) - QW'(wall_rd.ay);
               rx_ff    <= QW'(wall_rd.ax) - QW'(ax_ff);
               ry_ff    <= QW'(wall_rd.ay) - QW'(ay_ff);
               state_ff <= ST_MUL_DEN;
            end
            ST_MUL_DEN: begin
               den_ff   <= prod;
               state_ff <= ST_MUL_TN;
            end
            ST_MUL_TN: begin
               tn_ff    <= prod <<< FB;
               state_ff <= ST_MUL_UN;
            end
            ST_MUL_UN: begin
               un_ff    <= prod;
               state_ff <= ST_NORM;
            end
            ST_NORM: begin
               if (den_ff == '0) begin
                  // parallel or degenerate: no hit
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_WALL_RD;
               end else begin
                  if (den_ff[PW-1]) begin
                     den_ff <= -den_ff;
                     tn_ff  <= -tn_ff;
                     un_ff  <= -un_ff;
                  end
                  state_ff <= ST_TEST;
               end
            end
            ST_TEST: begin
               if (tn_ff[PW-1] || (tn_ff > den_ff) || un_ff[PW-1] || (un_ff > den_ff)) begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_WALL_RD;
               end else begin
                  axis_ff  <= 1'b0;
                  state_ff <= ST_MUL_LO;
               end
            end
            ST_MUL_LO: begin
               plo_ff   <= tn_ff[LO-1:0] * mag;
               state_ff <= ST_MUL_HI;
            end
            ST_MUL_HI: begin
               phi_ff   <= tn_ff[PW-1:LO] * mag;
               state_ff <= ST_DIV_GO;
            end
            ST_DIV_GO: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (div_done) begin
                  if (!axis_ff) begin
                     hqx_ff   <= q_signed;
                     axis_ff  <= 1'b1;
                     state_ff <= ST_MUL_LO;
                  end else begin
                     hqy_ff   <= q_signed;
                     state_ff <= ST_SQX;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_end_x    = rsp_end_x_ff;
   assign rsp_end_y    = rsp_end_y_ff;
   assign rsp_distance = rsp_distance_ff;

`ifndef SYNTHESIS
   // a result only leaves once the walk is over
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // a cast transaction always makes the core busy
   a_cast_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_command == rwnh_pkg::CMD_CAST)) |=> busy)
      else $error("cast accepted but core not busy");

   // loads never land in the table during a walk
   a_wr_idle: assert property (@(posedge clock) disable iff (reset)
      ram_wr |-> (state_ff == ST_IDLE))
      else $error("wall table written while busy");

   // divider finishes only while the sequencer waits for it
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider done outside its wait state");
`endif

endmodule

// ----- rtl/rwnh_ram.sv -----
// generic single write port ram with registered read
module rwnh_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rwnh_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module rwnh_div #(
   parameter int NUM_W  = 55,
   parameter int DEN_W  = 35,
   parameter int QUOT_W = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  numer,
   input  logic [DEN_W-1:0]  denom,
   output logic              done,
   output logic [QUOT_W-1:0] quot,
   output logic              rem_nz
);

   localparam int CW = $clog2(QUOT_W + 1);

   logic [DEN_W-1:0]  rem_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [QUOT_W-1:0] num_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic [CW-1:0]     cnt_ff;
   logic              run_ff;
   logic              done_ff;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;

   assign trial = {rem_ff, num_ff[QUOT_W-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= numer[NUM_W-1:QUOT_W];
            num_ff  <= numer[QUOT_W-1:0];
            den_ff  <= denom;
            quot_ff <= '0;
            cnt_ff  <= CW'(QUOT_W);
            run_ff  <= 1'b1;
         end else if (run_ff) begin
            if (!diff[DEN_W]) begin
               rem_ff  <= diff[DEN_W-1:0];
               quot_ff <= {quot_ff[QUOT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= trial[DEN_W-1:0];
               quot_ff <= {quot_ff[QUOT_W-2:0], 1'b0};
            end
            num_ff <= num_ff << 1;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done   = done_ff;
   assign quot   = quot_ff;
   assign rem_nz = |rem_ff;

endmodule
